### hdl/mrsp_pkg.sv
package mrsp_pkg;

    localparam int MESSAGE_DEPTH = 64;
    localparam int ADDR_W        = $clog2(MESSAGE_DEPTH);
    localparam int CNT_W         = $clog2(MESSAGE_DEPTH + 1);
    localparam int LENGTH_W      = 7;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 7;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(MESSAGE_DEPTH);

    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] EOX_BYTE    = 8'hF7;
    localparam logic [3:0] STATUS_CC   = 4'hB;
    localparam logic [3:0] STATUS_PC   = 4'hC;

    typedef enum logic [1:0] {
        EV_CONTROL      = 2'd0,
        EV_PRESET       = 2'd1,
        EV_SYSEX_BYTE   = 2'd2,
        EV_SYSEX_REJECT = 2'd3
    } t_event_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIDI_CHANNEL    = 3'd0,
        CFG_BANK_CONTROLLER = 3'd1,
        CFG_MAKER_FIRST     = 3'd2,
        CFG_MAKER_SECOND    = 3'd3,
        CFG_MAKER_THIRD     = 3'd4,
        CFG_TAP_TEMPO       = 3'd5,
        CFG_TUNER           = 3'd6
    } t_cfg_index;

    typedef struct packed {
        logic [4:0] midi_channel;
        logic [6:0] bank_controller;
        logic [6:0] maker_id_first;
        logic [6:0] maker_id_second;
        logic [6:0] maker_id_third;
        logic [6:0] tap_tempo_function;
        logic [6:0] tuner_function;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        midi_channel:       5'd0,
        bank_controller:    7'd0,
        maker_id_first:     7'd0,
        maker_id_second:    7'd1,
        maker_id_third:     7'd116,
        tap_tempo_function: 7'd16,
        tuner_function:     7'd13
    };

    typedef enum logic [2:0] {
        OP_STORE   = 3'd0,
        OP_CONTROL = 3'd1,
        OP_PRESET  = 3'd2,
        OP_REJECT  = 3'd3,
        OP_EMIT    = 3'd4
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data_a;
        logic [7:0]        data_b;
        logic [15:0]       preset;
        logic [CNT_W-1:0]  len;
    } t_cmd;

endpackage

### hdl/mrsp_byte_if.sv
interface mrsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### hdl/mrsp_event_if.sv
interface mrsp_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_kind;
    logic [7:0]  controller_number;
    logic [7:0]  controller_value;
    logic [15:0] preset_number;
    logic [7:0]  message_byte;
    logic        message_last;
    logic [6:0]  message_length;

    modport source (output valid, output event_kind, output controller_number,
                    output controller_value, output preset_number, output message_byte,
                    output message_last, output message_length, input ready);
    modport sink   (input valid, input event_kind, input controller_number,
                    input controller_value, input preset_number, input message_byte,
                    input message_last, input message_length, output ready);
endinterface

### hdl/mrsp_front.sv
module mrsp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mrsp_pkg::t_cfg i_cfg,
    mrsp_byte_if.sink      i_rx,
    input  logic           i_space,
    output logic           o_push,
    output mrsp_pkg::t_cmd o_cmd
);
    import mrsp_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE,
        M_CC_CTRL,
        M_CC_VALUE,
        M_PC,
        M_SYSEX
    } t_mode;

    t_mode            r_mode, n_mode;
    logic [7:0]       r_bank, n_bank;
    logic [7:0]       r_pend, n_pend;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_xor_thru, n_xor_thru;
    logic [7:0]       r_xor_before, n_xor_before;
    logic             r_ovf, n_ovf;
    logic [7:0]       r_hdr1, n_hdr1;
    logic [7:0]       r_hdr2, n_hdr2;
    logic [7:0]       r_hdr3, n_hdr3;
    logic [7:0]       r_func, n_func;
    logic [7:0]       r_last, n_last;

    logic             accept;
    logic [7:0]       b;
    logic             chan_ok;
    logic             start;
    logic             room;
    logic [CNT_W-1:0] msg_len;
    logic             ovf_all;
    logic [7:0]       func_byte;
    logic             skip_sum;
    logic             ok;

    assign i_rx.ready = i_space;
    assign accept     = i_rx.valid && i_space;
    assign b          = i_rx.rx_byte;
    assign chan_ok    = (i_cfg.midi_channel == 5'd0) ||
                        (i_cfg.midi_channel == ({1'b0, b[3:0]} + 5'd1));
    assign room       = r_count < DEPTH_C;

    always_comb begin
        n_mode       = r_mode;
        n_bank       = r_bank;
        n_pend       = r_pend;
        n_count      = r_count;
        n_xor_thru   = r_xor_thru;
        n_xor_before = r_xor_before;
        n_ovf        = r_ovf;
        n_hdr1       = r_hdr1;
        n_hdr2       = r_hdr2;
        n_hdr3       = r_hdr3;
        n_func       = r_func;
        n_last       = r_last;
        o_push       = 1'b0;
        o_cmd        = '0;
        start        = 1'b0;
        msg_len      = room ? r_count + CNT_W'(1) : r_count;
        ovf_all      = r_ovf || !room;
        // on a six byte message the function byte is the end byte itself
        func_byte    = (r_count == CNT_W'(5)) ? b : r_func;
        skip_sum     = (func_byte == {1'b0, i_cfg.tap_tempo_function}) ||
                       (func_byte == {1'b0, i_cfg.tuner_function});
        ok           = !ovf_all && (msg_len > CNT_W'(5)) &&
                       (r_hdr1 == {1'b0, i_cfg.maker_id_first}) &&
                       (r_hdr2 == {1'b0, i_cfg.maker_id_second}) &&
                       (r_hdr3 == {1'b0, i_cfg.maker_id_third}) &&
                       (skip_sum || (r_last == {1'b0, r_xor_before[6:0]}));

        if (accept) begin
            unique case (r_mode)
                M_IDLE: begin
                    if (b[7:4] == STATUS_CC) begin
                        if (chan_ok) n_mode = M_CC_CTRL;
                    end else if (b[7:4] == STATUS_PC) begin
                        if (chan_ok) n_mode = M_PC;
                    end else if (b == SYSEX_START) begin
                        start = 1'b1;
                    end
                end
                M_CC_CTRL: begin
                    n_pend = b;
                    n_mode = M_CC_VALUE;
                end
                M_CC_VALUE: begin
                    if (r_pend == {1'b0, i_cfg.bank_controller}) n_bank = b;
                    o_push       = 1'b1;
                    o_cmd.op     = OP_CONTROL;
                    o_cmd.data_a = r_pend;
                    o_cmd.data_b = b;
                    n_mode       = M_IDLE;
                end
                M_PC: begin
                    o_push       = 1'b1;
                    o_cmd.op     = OP_PRESET;
                    o_cmd.preset = {1'b0, r_bank, 7'd0} + {8'd0, b};
                    n_mode       = M_IDLE;
                end
                M_SYSEX: begin
                    if (b == SYSEX_START) begin
                        start = 1'b1;
                    end else if (b != EOX_BYTE) begin
                        if (room) begin
                            o_push       = 1'b1;
                            o_cmd.op     = OP_STORE;
                            o_cmd.addr   = r_count[ADDR_W-1:0];
                            o_cmd.data_a = b;
                            n_count      = r_count + CNT_W'(1);
                            if (r_count == CNT_W'(1)) n_hdr1 = b;
                            if (r_count == CNT_W'(2)) n_hdr2 = b;
                            if (r_count == CNT_W'(3)) n_hdr3 = b;
                            if (r_count == CNT_W'(5)) n_func = b;
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_xor_before = r_xor_thru;
                        n_xor_thru   = r_xor_thru ^ b;
                        n_last       = b;
                    end else begin
                        // end byte is not stored, the back end appends it
                        o_push    = 1'b1;
                        o_cmd.op  = ok ? OP_EMIT : OP_REJECT;
                        o_cmd.len = msg_len;
                        n_mode    = M_IDLE;
                    end
                end
                default: n_mode = M_IDLE;
            endcase

            if (start) begin
                o_push       = 1'b1;
                o_cmd.op     = OP_STORE;
                o_cmd.addr   = '0;
                o_cmd.data_a = SYSEX_START;
                n_count      = CNT_W'(1);
                n_xor_before = 8'd0;
                n_xor_thru   = SYSEX_START;
                n_ovf        = 1'b0;
                n_mode       = M_SYSEX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= M_IDLE;
            r_bank       <= 8'd0;
            r_pend       <= 8'd0;
            r_count      <= '0;
            r_xor_thru   <= 8'd0;
            r_xor_before <= 8'd0;
            r_ovf        <= 1'b0;
            r_hdr1       <= 8'd0;
            r_hdr2       <= 8'd0;
            r_hdr3       <= 8'd0;
            r_func       <= 8'd0;
            r_last       <= 8'd0;
        end else begin
            r_mode       <= n_mode;
            r_bank       <= n_bank;
            r_pend       <= n_pend;
            r_count      <= n_count;
            r_xor_thru   <= n_xor_thru;
            r_xor_before <= n_xor_before;
            r_ovf        <= n_ovf;
            r_hdr1       <= n_hdr1;
            r_hdr2       <= n_hdr2;
            r_hdr3       <= n_hdr3;
            r_func       <= n_func;
            r_last       <= n_last;
        end
    end

endmodule

### hdl/mrsp_cmd_fifo.sv
module mrsp_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mrsp_pkg::t_cmd i_cmd,
    output logic           o_space,
    output logic           o_valid,
    output mrsp_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import mrsp_pkg::*;

    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_fill;

    assign o_space = r_fill != (FIFO_AW + 1)'(FIFO_DEPTH);
    assign o_valid = r_fill != '0;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + FIFO_AW'(1);
            if (i_pop)  r_rd <= r_rd + FIFO_AW'(1);
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + (FIFO_AW + 1)'(1);
                2'b01:   r_fill <= r_fill - (FIFO_AW + 1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

### hdl/mrsp_back.sv
module mrsp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  mrsp_pkg::t_cmd i_cmd,
    output logic           o_pop,
    mrsp_event_if.source   o_evt
);
    import mrsp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_SEND
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_len;
    logic [7:0]       r_mem [MESSAGE_DEPTH];
    logic [7:0]       r_rd_data;

    logic             r_out_valid;
    t_event_kind      r_kind;
    logic [7:0]       r_ctrl_num;
    logic [7:0]       r_ctrl_val;
    logic [15:0]      r_preset;
    logic [7:0]       r_msg_byte;
    logic             r_msg_last;
    logic [CNT_W-1:0] r_msg_len;

    logic             can_load;
    logic             at_end;
    logic             load_evt;

    assign can_load = !r_out_valid || o_evt.ready;
    assign at_end   = r_idx == (r_len - CNT_W'(1));
    assign o_pop    = (r_state == S_IDLE) && i_valid &&
                      ((i_cmd.op == OP_STORE) || (i_cmd.op == OP_EMIT) || can_load);
    assign load_evt = (o_pop && (i_cmd.op != OP_STORE) && (i_cmd.op != OP_EMIT)) ||
                      ((r_state == S_SEND) && can_load);

    // message store: one write port from the queue, one read port for the drain
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.op == OP_STORE)) r_mem[i_cmd.addr] <= i_cmd.data_a;
        r_rd_data <= r_mem[r_idx[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_len       <= '0;
        end else begin
            if (load_evt) begin
                r_out_valid <= 1'b1;
            end else if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        unique case (i_cmd.op)
                            OP_CONTROL: begin
                                r_kind     <= EV_CONTROL;
                                r_ctrl_num <= i_cmd.data_a;
                                r_ctrl_val <= i_cmd.data_b;
                                r_preset   <= 16'd0;
                                r_msg_byte <= 8'd0;
                                r_msg_last <= 1'b0;
                                r_msg_len  <= '0;
                            end
                            OP_PRESET: begin
                                r_kind     <= EV_PRESET;
                                r_ctrl_num <= 8'd0;
                                r_ctrl_val <= 8'd0;
                                r_preset   <= i_cmd.preset;
                                r_msg_byte <= 8'd0;
                                r_msg_last <= 1'b0;
                                r_msg_len  <= '0;
                            end
                            OP_REJECT: begin
                                r_kind     <= EV_SYSEX_REJECT;
                                r_ctrl_num <= 8'd0;
                                r_ctrl_val <= 8'd0;
                                r_preset   <= 16'd0;
                                r_msg_byte <= 8'd0;
                                r_msg_last <= 1'b0;
                                r_msg_len  <= '0;
                            end
                            OP_EMIT: begin
                                r_len   <= i_cmd.len;
                                r_idx   <= '0;
                                r_state <= S_FETCH;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FETCH: r_state <= S_SEND;
                S_SEND: begin
                    if (can_load) begin
                        r_kind      <= EV_SYSEX_BYTE;
                        r_ctrl_num  <= 8'd0;
                        r_ctrl_val  <= 8'd0;
                        r_preset    <= 16'd0;
                        r_msg_byte  <= at_end ? EOX_BYTE : r_rd_data;
                        r_msg_last  <= at_end;
                        r_msg_len   <= r_len;
                        if (at_end) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + CNT_W'(1);
                            r_state <= S_FETCH;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_evt.valid             = r_out_valid;
    assign o_evt.event_kind        = r_kind;
    assign o_evt.controller_number = r_ctrl_num;
    assign o_evt.controller_value  = r_ctrl_val;
    assign o_evt.preset_number     = r_preset;
    assign o_evt.message_byte      = r_msg_byte;
    assign o_evt.message_last      = r_msg_last;
    assign o_evt.message_length    = LENGTH_W'(r_msg_len);

endmodule

### hdl/midi_receive_sysex_parser.sv
// MIDI receive parser. Takes one received byte per beat on i_rx and reports control changes on
// the configured channel, preset changes (bank*128 + program) and checked system-exclusive
// messages, which leave on o_evt one byte per beat, ending with the end byte marked last, or as
// a single reject beat. A front end classifies one byte per cycle and hands commands to a
// four-entry queue; a back end owns the 64-byte message store and the output register. Input
// is taken every cycle while the queue has room. The back end takes control, preset and store
// commands from the queue; an accepted message is drained byte by byte through a fetch and a
// send state, because each store read is registered before it goes out. Bytes
// received during a drain queue up, and i_rx stalls once four commands wait. Configuration
// writes are taken at any edge on the write port and should be made while the block is idle.
module midi_receive_sysex_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mrsp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mrsp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mrsp_byte_if.sink                       i_rx,
    mrsp_event_if.source                    o_evt
);
    import mrsp_pkg::*;

    t_cfg r_cfg;
    logic q_push;
    t_cmd q_in;
    logic q_space;
    logic q_valid;
    t_cmd q_out;
    logic q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_MIDI_CHANNEL:    r_cfg.midi_channel       <= i_cfg_data[4:0];
                CFG_BANK_CONTROLLER: r_cfg.bank_controller    <= i_cfg_data;
                CFG_MAKER_FIRST:     r_cfg.maker_id_first     <= i_cfg_data;
                CFG_MAKER_SECOND:    r_cfg.maker_id_second    <= i_cfg_data;
                CFG_MAKER_THIRD:     r_cfg.maker_id_third     <= i_cfg_data;
                CFG_TAP_TEMPO:       r_cfg.tap_tempo_function <= i_cfg_data;
                CFG_TUNER:           r_cfg.tuner_function     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mrsp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_rx    (i_rx),
        .i_space (q_space),
        .o_push  (q_push),
        .o_cmd   (q_in)
    );

    mrsp_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_space (q_space),
        .o_valid (q_valid),
        .o_cmd   (q_out),
        .i_pop   (q_pop)
    );

    mrsp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_out),
        .o_pop   (q_pop),
        .o_evt   (o_evt)
    );

endmodule

### hdl/mrsp_checker.sv
module mrsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_evt_valid,
    input logic        i_evt_ready,
    input logic [1:0]  i_evt_kind,
    input logic [7:0]  i_evt_byte,
    input logic        i_evt_last,
    input logic [6:0]  i_evt_len
);
    import mrsp_pkg::*;

    logic r_in_msg;
    logic beat;

    assign beat = i_evt_valid && i_evt_ready;

    // tracks whether a message drain has started and not yet ended
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
        end else if (beat && (i_evt_kind == EV_SYSEX_BYTE)) begin
            r_in_msg <= !i_evt_last;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt_valid && !i_evt_ready |=> i_evt_valid && $stable(i_evt_kind) &&
        $stable(i_evt_byte) && $stable(i_evt_last))
        else $error("event changed while stalled");

    a_no_interleave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_msg && i_evt_valid |-> i_evt_kind == EV_SYSEX_BYTE)
        else $error("other event inside a message drain");

    a_first_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_msg && i_evt_valid && (i_evt_kind == EV_SYSEX_BYTE)
        |-> (i_evt_byte == SYSEX_START) && !i_evt_last)
        else $error("message does not open with start byte");

    a_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt_valid && (i_evt_kind == EV_SYSEX_BYTE) && i_evt_last
        |-> (i_evt_byte == EOX_BYTE) && (i_evt_len > 7'd5))
        else $error("bad final message beat");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_evt_valid)
        else $error("output valid after reset");

endmodule

bind midi_receive_sysex_parser mrsp_checker u_mrsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_evt_valid (o_evt.valid),
    .i_evt_ready (o_evt.ready),
    .i_evt_kind  (o_evt.event_kind),
    .i_evt_byte  (o_evt.message_byte),
    .i_evt_last  (o_evt.message_last),
    .i_evt_len   (o_evt.message_length)
);

### test/tb_midi_receive_sysex_parser.sv
module tb_midi_receive_sysex_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import mrsp_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int QUIET_LIMIT   = 4000;
    localparam int PHASE_ITEMS   = 80;
    localparam int N_PHASES      = 6;

    typedef enum {PM_IDLE, PM_CC_CTRL, PM_CC_VALUE, PM_PROGRAM, PM_SYSEX} t_parse_mode;

    typedef struct packed {
        t_event_kind kind;
        logic [7:0]  ctrl_num;
        logic [7:0]  ctrl_val;
        logic [15:0] preset;
        logic [7:0]  data;
        logic        last;
        logic [6:0]  length;
    } t_midi_event;

    typedef struct packed {
        logic [7:0]  rx;
        bit          typed;
        t_midi_event ev;
    } t_stim_row;

    // hand-written expectations only where the answer is obvious
    localparam t_stim_row DIRECTED [24] = '{
        '{8'hB0, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h7F, 1'b1, '{EV_CONTROL, 8'd0, 8'd127, 16'd0, 8'd0, 1'b0, 7'd0}},
        '{8'hCF, 1'b0, '0},
        '{8'h7F, 1'b1, '{EV_PRESET, 8'd0, 8'd0, 16'd16383, 8'd0, 1'b0, 7'd0}},
        '{8'hB5, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{SYSEX_START, 1'b1, '{EV_CONTROL, 8'd255, 8'd240, 16'd0, 8'd0, 1'b0, 7'd0}},
        '{8'h80, 1'b0, '0},
        '{8'hFE, 1'b0, '0},
        '{EOX_BYTE, 1'b0, '0},
        '{8'hC3, 1'b0, '0},
        '{8'h00, 1'b1, '{EV_PRESET, 8'd0, 8'd0, 16'd16256, 8'd0, 1'b0, 7'd0}},
        '{SYSEX_START, 1'b0, '0},
        '{EOX_BYTE, 1'b1, '{EV_SYSEX_REJECT, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, 7'd0}},
        '{SYSEX_START, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{SYSEX_START, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h74, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h10, 1'b0, '0},
        '{EOX_BYTE, 1'b0, '0}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mrsp_byte_if  rx_if ();
    mrsp_event_if evt_if ();

    midi_receive_sysex_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rx        (rx_if),
        .o_evt       (evt_if)
    );

    // parser mirror
    t_cfg        mp_cfg      = CFG_RESET;
    t_parse_mode mp_mode     = PM_IDLE;
    logic [7:0]  mp_bank     = 8'd0;
    logic [7:0]  mp_ctrl     = 8'd0;
    logic [7:0]  mp_store [MESSAGE_DEPTH];
    logic [6:0]  mp_count    = 7'd0;
    logic [7:0]  mp_xor_now  = 8'd0;
    logic [7:0]  mp_xor_prev = 8'd0;
    logic        mp_overflow = 1'b0;

    t_midi_event stepped_events [$];
    t_midi_event pending_events [$];

    int n_fail       = 0;
    int items_sent   = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void note_event(input t_event_kind k, input logic [7:0] cn,
                                       input logic [7:0] cv, input logic [15:0] pn,
                                       input logic [7:0] mb, input logic ml,
                                       input logic [6:0] ln);
        stepped_events.push_back('{k, cn, cv, pn, mb, ml, ln});
    endfunction

    function automatic bit channel_match(input logic [7:0] b);
        return mp_cfg.midi_channel == 5'd0 || mp_cfg.midi_channel == {1'b0, b[3:0]} + 5'd1;
    endfunction

    function automatic void open_capture();
        mp_store[0] = SYSEX_START;
        mp_count    = 7'd1;
        mp_xor_prev = 8'h00;
        mp_xor_now  = SYSEX_START;
        mp_overflow = 1'b0;
        mp_mode     = PM_SYSEX;
    endfunction

    function automatic void parse_rx_byte(input logic [7:0] b);
        bit ok;
        int len;
        case (mp_mode)
            PM_CC_CTRL: begin
                mp_ctrl = b;
                mp_mode = PM_CC_VALUE;
            end
            PM_CC_VALUE: begin
                if (mp_ctrl == 8'(mp_cfg.bank_controller))
                    mp_bank = b;
                mp_mode = PM_IDLE;
                note_event(EV_CONTROL, mp_ctrl, b, 16'd0, 8'd0, 1'b0, 7'd0);
            end
            PM_PROGRAM: begin
                mp_mode = PM_IDLE;
                note_event(EV_PRESET, 8'd0, 8'd0, (16'(mp_bank) << 7) + 16'(b), 8'd0, 1'b0,
                           7'd0);
            end
            PM_SYSEX: begin
                if (b == SYSEX_START) begin
                    open_capture();
                end else begin
                    if (mp_count < MESSAGE_DEPTH) begin
                        mp_store[mp_count] = b;
                        mp_count++;
                    end else begin
                        mp_overflow = 1'b1;
                    end
                    if (b != EOX_BYTE) begin
                        mp_xor_prev = mp_xor_now;
                        mp_xor_now  = mp_xor_now ^ b;
                    end else begin
                        mp_mode = PM_IDLE;
                        len = mp_count;
                        ok = !mp_overflow && len > 5 &&
                             mp_store[1] == 8'(mp_cfg.maker_id_first) &&
                             mp_store[2] == 8'(mp_cfg.maker_id_second) &&
                             mp_store[3] == 8'(mp_cfg.maker_id_third);
                        // tap tempo and tuner messages carry no checksum
                        if (ok && mp_store[5] != 8'(mp_cfg.tap_tempo_function) &&
                            mp_store[5] != 8'(mp_cfg.tuner_function))
                            ok = mp_store[len-2] == (mp_xor_prev & 8'h7F);
                        if (!ok)
                            note_event(EV_SYSEX_REJECT, 8'd0, 8'd0, 16'd0, 8'd0, 1'b0, 7'd0);
                        else
                            for (int i = 0; i < len; i++)
                                note_event(EV_SYSEX_BYTE, 8'd0, 8'd0, 16'd0, mp_store[i],
                                           i == len - 1, 7'(len));
                    end
                end
            end
            default: begin
                if (b[7:4] == STATUS_CC) begin
                    if (channel_match(b))
                        mp_mode = PM_CC_CTRL;
                end else if (b[7:4] == STATUS_PC) begin
                    if (channel_match(b))
                        mp_mode = PM_PROGRAM;
                end else if (b == SYSEX_START) begin
                    open_capture();
                end
            end
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input t_midi_event want = '0);
        t_parse_mode was;
        if ($urandom_range(99) < tx_idle_pct) begin
            rx_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (rx_if.ready !== 1'b1);
        was = mp_mode;
        parse_rx_byte(b);
        // bytes the parser simply drops are not counted
        if (!(was == PM_IDLE && mp_mode == PM_IDLE))
            items_sent++;
        if (typed)
            pending_events.push_back(want);
        else
            foreach (stepped_events[i])
                pending_events.push_back(stepped_events[i]);
        stepped_events.delete();
    endtask

    task automatic hold_until_drained();
        rx_if.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic finish_open_message();
        while (mp_mode != PM_IDLE)
            send_byte((mp_mode == PM_SYSEX) ? EOX_BYTE : 8'h00);
    endtask

    task automatic load_config(input t_cfg c);
        t_cfg_index order [7] = '{CFG_MIDI_CHANNEL, CFG_BANK_CONTROLLER, CFG_MAKER_FIRST,
                                  CFG_MAKER_SECOND, CFG_MAKER_THIRD, CFG_TAP_TEMPO, CFG_TUNER};
        logic [CFG_DATA_W-1:0] value [7];
        value = '{7'(c.midi_channel), c.bank_controller, c.maker_id_first, c.maker_id_second,
                  c.maker_id_third, c.tap_tempo_function, c.tuner_function};
        for (int k = 0; k < 7; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= order[k];
            i_cfg_data  <= value[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        mp_cfg = c;
    endtask

    function automatic t_cfg random_cfg(input logic [4:0] chan);
        t_cfg c;
        c.midi_channel       = chan;
        c.bank_controller    = 7'($urandom_range(127));
        c.maker_id_first     = 7'($urandom_range(127));
        c.maker_id_second    = 7'($urandom_range(127));
        c.maker_id_third     = 7'($urandom_range(127));
        c.tap_tempo_function = 7'($urandom_range(127));
        c.tuner_function     = 7'($urandom_range(127));
        return c;
    endfunction

    function automatic logic [3:0] pick_channel();
        if (mp_cfg.midi_channel inside {[5'd1:5'd16]} && $urandom_range(3) != 0)
            return 4'(mp_cfg.midi_channel - 5'd1);
        return 4'($urandom_range(15));
    endfunction

    task automatic run_random(input int n_items);
        int         start;
        int         sel;
        int         n;
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] head [5];
        logic [7:0] frame [$];
        start = items_sent;
        while (items_sent - start < n_items) begin
            sel = $urandom_range(99);
            frame.delete();
            if (sel < 3) begin
                hold_until_drained();
            end else if (sel < 22) begin
                frame.push_back({STATUS_CC, pick_channel()});
                case ($urandom_range(9)) inside
                    [0:2]:   frame.push_back(8'(mp_cfg.bank_controller));
                    3:       frame.push_back(8'($urandom_range(128, 255)));
                    default: frame.push_back(8'($urandom_range(127)));
                endcase
                frame.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                         : 8'($urandom_range(127)));
            end else if (sel < 36) begin
                frame.push_back({STATUS_PC, pick_channel()});
                frame.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                         : 8'($urandom_range(127)));
            end else if (sel < 78) begin
                // now and then an abandoned start just before, so the capture restarts
                if ($urandom_range(19) == 0) begin
                    frame.push_back(SYSEX_START);
                    repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(127)));
                end
                head[0] = 8'(mp_cfg.maker_id_first);
                head[1] = 8'(mp_cfg.maker_id_second);
                head[2] = 8'(mp_cfg.maker_id_third);
                if ($urandom_range(9) == 0)
                    head[$urandom_range(2)] = 8'($urandom_range(127));
                head[3] = 8'($urandom_range(127));
                case ($urandom_range(7)) inside
                    [0:1]:   head[4] = 8'(mp_cfg.tap_tempo_function);
                    2:       head[4] = 8'(mp_cfg.tuner_function);
                    default: head[4] = 8'($urandom_range(127));
                endcase
                sel = $urandom_range(99);
                if (sel < 88)      n = $urandom_range(0, 6);
                else if (sel < 94) n = $urandom_range(40, 56);
                else               n = $urandom_range(57, 62);   // runs past the store
                frame.push_back(SYSEX_START);
                sum = SYSEX_START;
                foreach (head[i]) begin
                    frame.push_back(head[i]);
                    sum = sum ^ head[i];
                end
                repeat (n) begin
                    b = 8'($urandom_range(127));
                    frame.push_back(b);
                    sum = sum ^ b;
                end
                sum = sum & 8'h7F;
                if ($urandom_range(6) == 0)
                    sum = sum ^ 8'($urandom_range(1, 127));
                frame.push_back(sum);
                frame.push_back(EOX_BYTE);
            end else if (sel < 88) begin
                // short captures, often with a proper header, sometimes never closed
                frame.push_back(SYSEX_START);
                if ($urandom_range(1) == 0) begin
                    frame.push_back(8'(mp_cfg.maker_id_first));
                    frame.push_back(8'(mp_cfg.maker_id_second));
                    frame.push_back(8'(mp_cfg.maker_id_third));
                end
                repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom_range(255)));
                if ($urandom_range(4) != 0)
                    frame.push_back(EOX_BYTE);
            end else begin
                repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom_range(255)));
            end
            foreach (frame[i])
                send_byte(frame[i]);
        end
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk)
        evt_if.ready <= ($urandom_range(99) >= rx_stall_pct);

    always @(posedge i_clk) begin
        t_midi_event want;
        if (i_rst_n && evt_if.valid === 1'b1 && evt_if.ready === 1'b1) begin
            if (pending_events.size() == 0) begin
                $error("event beat with nothing expected: kind %0d", evt_if.event_kind);
                n_fail++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", want.kind, evt_if.event_kind);
                check_field("controller_number", want.ctrl_num, evt_if.controller_number);
                check_field("controller_value", want.ctrl_val, evt_if.controller_value);
                check_field("preset_number", want.preset, evt_if.preset_number);
                check_field("message_byte", want.data, evt_if.message_byte);
                check_field("message_last", want.last, evt_if.message_last);
                check_field("message_length", want.length, evt_if.message_length);
            end
        end
    end

    // no beat on either side for too long means the block has hung
    always @(posedge i_clk) begin
        if ((rx_if.valid === 1'b1 && rx_if.ready === 1'b1) ||
            (evt_if.valid === 1'b1 && evt_if.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_cfg plan [N_PHASES];
        int   tx_pct [4] = '{0, 68, 0, 28};
        int   rx_pct [4] = '{0, 0, 68, 28};
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_MIDI_CHANNEL;
        i_cfg_data    <= '0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[r])
            send_byte(DIRECTED[r].rx, DIRECTED[r].typed, DIRECTED[r].ev);

        plan[0] = '{5'd16, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127};
        plan[1] = '0;
        plan[2] = random_cfg(5'($urandom_range(1, 16)));
        plan[3] = random_cfg(5'd17);     // beyond sixteen: no channel matches
        plan[4] = random_cfg(5'($urandom_range(1, 16)));
        plan[5] = random_cfg(5'd0);

        for (int p = 0; p < N_PHASES; p++) begin
            finish_open_message();
            hold_until_drained();
            load_config(plan[p]);
            tx_idle_pct  = tx_pct[p % 4];
            rx_stall_pct = rx_pct[p % 4];
            run_random(PHASE_ITEMS);
        end
        finish_open_message();
        hold_until_drained();

        if (n_fail == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
